// File: hdl/ppp_pkg.sv
// Shared types, constants and helper functions of the perspective point projector.
`default_nettype none

package ppp_pkg;

   localparam int TAG_SLOTS_DEFAULT = 16;

   localparam int COEF_W  = 32;
   localparam int POS_W   = 32;
   localparam int IDX_W   = 4;
   localparam int TAG_W   = 4;
   localparam int OUT_W   = 24;
   localparam int ACC_W   = 58;   // clip coordinate accumulators
   localparam int NUM_W   = 59;   // clip y plus or minus the height term
   localparam int MAG_W   = 58;   // magnitude of a numerator
   localparam int DIVN_W  = 79;   // numerator times viewport scale
   localparam int DIVD_W  = 57;   // positive clip w
   localparam int QUO_W   = 25;   // quotient, capped at 2^24
   localparam int RES_W   = 26;   // signed viewport offset
   localparam int SUM_W   = 27;   // centre plus offset before saturation
   localparam int MUL_W   = 33;
   localparam int PROD_W  = 66;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_MARGIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NEAR_LIMIT    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT_OFFSET = 3'd4;

   localparam logic [13:0] SCREEN_WIDTH_RESET  = 14'd1920;
   localparam logic [13:0] SCREEN_HEIGHT_RESET = 14'd1080;
   localparam logic [9:0]  CENTER_MARGIN_RESET = 10'd20;
   localparam logic [15:0] NEAR_LIMIT_RESET    = 16'd655;
   localparam logic [19:0] HEIGHT_OFFSET_RESET = 20'd25600;

   localparam logic [1:0] STATUS_VISIBLE = 2'd0;
   localparam logic [1:0] STATUS_BEHIND  = 2'd1;
   localparam logic [1:0] STATUS_CENTRED = 2'd2;

   localparam logic [QUO_W-1:0] QUO_CAP = 25'h1000000;

   typedef enum logic {
      OP_LOAD,
      OP_POINT
   } op_type;

   typedef struct packed {
      op_type                    op;
      logic [IDX_W-1:0]          coef_index;
      logic signed [COEF_W-1:0]  coef_value;
      logic signed [POS_W-1:0]   pos_x;
      logic signed [POS_W-1:0]   pos_y;
      logic signed [POS_W-1:0]   pos_z;
      logic [TAG_W-1:0]          tag;
   } cmd_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_MUL,
      BK_ACC,
      BK_CHECK,
      BK_KLO,
      BK_KHI,
      BK_DGO,
      BK_DWAIT,
      BK_CENTRE,
      BK_OUT
   } back_state_type;

   // Reduce a tag by repeated subtraction; only ever evaluated on constants.
   function automatic int tag_reduce(input int t, input int slots);
      int r;
      r = t;
      for (int i = 0; i < 16; i++) begin
         if (r >= slots) begin
            r = r - slots;
         end
      end
      return r;
   endfunction

   function automatic logic signed [OUT_W-1:0] sat24(input logic signed [SUM_W-1:0] v);
      logic signed [OUT_W-1:0] r;
      if (v > $signed(27'sd8388607)) begin
         r = 24'sh7FFFFF;
      end else if (v < $signed(-27'sd8388608)) begin
         r = 24'sh800000;
      end else begin
         r = v[OUT_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: hdl/ppp_front.sv
// Input stage: takes request beats, classifies them and reduces the tag.
`default_nettype none

module ppp_front
   import ppp_pkg::*;
#(
   parameter int TAG_SLOTS = TAG_SLOTS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic                     req_type,
   input  wire logic [IDX_W-1:0]         req_coef_index,
   input  wire logic signed [COEF_W-1:0] req_coef_value,
   input  wire logic signed [POS_W-1:0]  req_pos_x,
   input  wire logic signed [POS_W-1:0]  req_pos_y,
   input  wire logic signed [POS_W-1:0]  req_pos_z,
   input  wire logic [TAG_W-1:0]         req_point_tag,
   output logic                          cmd_valid,
   output cmd_type                       cmd,
   input  wire logic                     cmd_ready
);

   logic [TAG_W-1:0] tag_lut [16];
   logic             valid_ff, valid_in;
   cmd_type          cmd_ff;
   logic             accept;

   for (genvar g = 0; g < 16; g++) begin : g_tag
      assign tag_lut[g] = TAG_W'(tag_reduce(g, TAG_SLOTS));
   end

   assign req_stall = valid_ff && !cmd_ready;
   assign accept    = req_valid && !req_stall;
   assign valid_in  = accept || (valid_ff && !cmd_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff.op         <= req_type ? OP_POINT : OP_LOAD;
         cmd_ff.coef_index <= req_coef_index;
         cmd_ff.coef_value <= req_coef_value;
         cmd_ff.pos_x      <= req_pos_x;
         cmd_ff.pos_y      <= req_pos_y;
         cmd_ff.pos_z      <= req_pos_z;
         cmd_ff.tag        <= tag_lut[req_point_tag];
      end
   end

   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;

endmodule

`default_nettype wire

// File: hdl/ppp_queue.sv
// Two-entry command queue between the front and back sections.
`default_nettype none

module ppp_queue
   import ppp_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push_valid,
   input  cmd_type   push_cmd,
   output logic      push_ready,
   output logic      pop_valid,
   output cmd_type   pop_cmd,
   input  wire logic pop_ready
);

   cmd_type    mem_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] count_ff;
   logic       push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_cmd    = mem_ff[rd_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_ready && pop_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ff <= !wr_ff;
         end
         if (pop) begin
            rd_ff <= !rd_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// File: hdl/ppp_div.sv
// Restoring divider, one quotient bit a cycle, quotient capped at 2^24.
`default_nettype none

module ppp_div
   import ppp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DIVN_W-1:0] dividend,
   input  wire logic [DIVD_W-1:0] divisor,
   output logic                   done,
   output logic [QUO_W-1:0]       quotient
);

   logic              busy_ff, done_ff;
   logic [4:0]        cnt_ff;
   logic [DIVD_W-1:0] rem_ff, d_ff, rem_in;
   logic [QUO_W-1:0]  sh_ff, q_ff, q_in;
   logic [DIVD_W:0]   trial, diff;
   logic              ge;
   logic [DIVN_W-QUO_W-1:0] head;

   assign head  = dividend[DIVN_W-1:QUO_W];
   assign trial = {rem_ff, sh_ff[QUO_W-1]};
   assign diff  = trial - {1'b0, d_ff};
   assign ge    = (trial >= {1'b0, d_ff});
   assign rem_in = ge ? diff[DIVD_W-1:0] : trial[DIVD_W-1:0];
   assign q_in   = {q_ff[QUO_W-2:0], ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            if ({3'b0, head} >= divisor) begin
               done_ff <= 1'b1;
            end else begin
               busy_ff <= 1'b1;
            end
         end else if (busy_ff && cnt_ff == 5'd0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= DIVD_W'(head);
         sh_ff  <= dividend[QUO_W-1:0];
         d_ff   <= divisor;
         cnt_ff <= 5'(QUO_W - 1);
         q_ff   <= QUO_CAP;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         sh_ff  <= {sh_ff[QUO_W-2:0], 1'b0};
         cnt_ff <= cnt_ff - 5'd1;
         if (cnt_ff == 5'd0 && q_in > QUO_CAP) begin
            q_ff <= QUO_CAP;
         end else begin
            q_ff <= q_in;
         end
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

`default_nettype wire

// File: hdl/ppp_back.sv
// Execution engine: matrix store, shared multiplier, division sequencing, result register.
`default_nettype none

module ppp_back
   import ppp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   input  cmd_type                cmd,
   output logic                   cmd_pop,
   input  wire logic [13:0]       screen_width,
   input  wire logic [13:0]       screen_height,
   input  wire logic [9:0]        center_margin,
   input  wire logic [15:0]       near_limit,
   input  wire logic [19:0]       height_offset,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [TAG_W-1:0]       rsp_result_tag,
   output logic [1:0]             rsp_status,
   output logic signed [OUT_W-1:0] rsp_screen_x,
   output logic signed [OUT_W-1:0] rsp_screen_top,
   output logic signed [OUT_W-1:0] rsp_screen_bottom
);

   back_state_type state_ff, state_in;

   logic signed [COEF_W-1:0] mat_ff [16];
   logic signed [POS_W-1:0]  px_ff, py_ff, pz_ff;
   logic [TAG_W-1:0]         tag_ff;
   logic [3:0]               mstep_ff;
   logic [1:0]               job_ff;
   logic signed [ACC_W-1:0]  xc_ff, yc_ff, wc_ff, ht_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic [MAG_W-1:0]         mag_ff;
   logic                     neg_ff;
   logic [52:0]              nlo_ff;
   logic signed [RES_W-1:0]  res_ff [4];
   logic [1:0]               status_ff;

   logic                      rsp_valid_ff;
   logic [TAG_W-1:0]          rsp_tag_ff;
   logic [1:0]                rsp_status_ff;
   logic signed [OUT_W-1:0]   rsp_x_ff, rsp_top_ff, rsp_bot_ff;

   logic                      mat_we, div_start, div_done, rsp_load;
   logic [QUO_W-1:0]          div_q;
   logic [DIVN_W-1:0]         dividend;
   logic signed [MUL_W-1:0]   mul_a, mul_b;
   logic [3:0]                widx;
   logic [1:0]                psel;
   logic signed [POS_W-1:0]   pos_cur;
   logic [20:0]               kscale;
   logic signed [NUM_W-1:0]   num_cur;
   logic                      neg_cur;
   logic [NUM_W-1:0]          mag_full;
   logic signed [ACC_W-1:0]   prod_sh;
   logic                      behind, centred;
   logic [RES_W-1:0]          abs_dx, abs_dy;
   logic [RES_W-1:0]          margin_q8;
   logic signed [SUM_W-1:0]   sum_x, sum_top, sum_bot, kw_s, kh_s;
   logic signed [RES_W-1:0]   res_in;

   // clip row and coordinate for each multiply step
   always_comb begin
      widx = 4'd0;
      psel = 2'd0;
      case (mstep_ff)
         4'd0:    begin widx = 4'd0;  psel = 2'd0; end
         4'd1:    begin widx = 4'd4;  psel = 2'd1; end
         4'd3:    begin widx = 4'd1;  psel = 2'd0; end
         4'd4:    begin widx = 4'd5;  psel = 2'd1; end
         4'd5:    begin widx = 4'd9;  psel = 2'd2; end
         4'd6:    begin widx = 4'd3;  psel = 2'd0; end
         4'd7:    begin widx = 4'd7;  psel = 2'd1; end
         4'd8:    begin widx = 4'd11; psel = 2'd2; end
         4'd9:    begin widx = 4'd9;  psel = 2'd3; end
         default: begin widx = 4'd0;  psel = 2'd0; end
      endcase
   end

   always_comb begin
      case (psel)
         2'd0:    pos_cur = px_ff;
         2'd1:    pos_cur = py_ff;
         2'd2:    pos_cur = pz_ff;
         default: pos_cur = $signed({12'b0, height_offset});
      endcase
   end

   assign kscale = (job_ff == 2'd0) ? {screen_width, 7'b0} : {screen_height, 7'b0};

   always_comb begin
      case (job_ff)
         2'd0:    num_cur = NUM_W'(xc_ff);
         2'd1:    num_cur = NUM_W'(yc_ff);
         2'd2:    num_cur = NUM_W'(yc_ff) + NUM_W'(ht_ff);
         default: num_cur = NUM_W'(yc_ff) - NUM_W'(ht_ff);
      endcase
   end

   assign neg_cur  = num_cur[NUM_W-1];
   assign mag_full = neg_cur ? (~num_cur + 1'b1) : num_cur;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         BK_MUL: begin
            // the row 0, column 2 element is forced to zero
            if (mstep_ff != 4'd2) begin
               mul_a = MUL_W'(mat_ff[widx]);
            end
            mul_b = MUL_W'(pos_cur);
         end
         BK_KLO: begin
            mul_a = $signed({1'b0, mag_full[31:0]});
            mul_b = $signed({12'b0, kscale});
         end
         BK_KHI: begin
            mul_a = $signed({7'b0, mag_ff[MAG_W-1:32]});
            mul_b = $signed({12'b0, kscale});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_sh  = $signed({{2{prod_ff[63]}}, prod_ff[63:8]});
   assign dividend = {26'b0, nlo_ff} + {prod_ff[46:0], 32'b0};

   assign behind = (wc_ff <= 0) || (wc_ff < $signed({42'b0, near_limit}));

   assign abs_dx    = res_ff[0][RES_W-1] ? -res_ff[0] : res_ff[0];
   assign abs_dy    = res_ff[1][RES_W-1] ? -res_ff[1] : res_ff[1];
   assign margin_q8 = {8'b0, center_margin, 8'b0};
   assign centred   = (abs_dx < margin_q8) && (abs_dy < margin_q8);

   assign res_in = neg_ff ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});

   assign kw_s    = $signed({6'b0, screen_width, 7'b0});
   assign kh_s    = $signed({6'b0, screen_height, 7'b0});
   assign sum_x   = kw_s + SUM_W'(res_ff[0]);
   assign sum_top = kh_s - SUM_W'(res_ff[2]);
   assign sum_bot = kh_s - SUM_W'(res_ff[3]);

   ppp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (wc_ff[DIVD_W-1:0]),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (cmd_valid && cmd.op == OP_POINT) begin
               state_in = BK_MUL;
            end
         end
         BK_MUL:   state_in = BK_ACC;
         BK_ACC:   state_in = (mstep_ff == 4'd9) ? BK_CHECK : BK_MUL;
         BK_CHECK: state_in = behind ? BK_OUT : BK_KLO;
         BK_KLO:   state_in = BK_KHI;
         BK_KHI:   state_in = BK_DGO;
         BK_DGO:   state_in = BK_DWAIT;
         BK_DWAIT: begin
            if (div_done) begin
               if (job_ff == 2'd1) begin
                  state_in = BK_CENTRE;
               end else if (job_ff == 2'd3) begin
                  state_in = BK_OUT;
               end else begin
                  state_in = BK_KLO;
               end
            end
         end
         BK_CENTRE: state_in = centred ? BK_OUT : BK_KLO;
         BK_OUT:    state_in = rsp_load ? BK_IDLE : BK_OUT;
         default:   state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      cmd_pop   = 1'b0;
      mat_we    = 1'b0;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            cmd_pop = cmd_valid;
            mat_we  = cmd_valid && cmd.op == OP_LOAD;
         end
         BK_DGO:  div_start = 1'b1;
         BK_OUT:  rsp_load  = !rsp_valid_ff || !rsp_stall;
         default: begin
            cmd_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 16; i++) begin
            mat_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (mat_we) begin
            mat_ff[cmd.coef_index] <= cmd.coef_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      case (state_ff)
         BK_IDLE: begin
            px_ff    <= cmd.pos_x;
            py_ff    <= cmd.pos_y;
            pz_ff    <= cmd.pos_z;
            tag_ff   <= cmd.tag;
            xc_ff    <= ACC_W'(mat_ff[12]);
            yc_ff    <= ACC_W'(mat_ff[13]);
            wc_ff    <= ACC_W'(mat_ff[15]);
            ht_ff    <= '0;
            mstep_ff <= 4'd0;
         end
         BK_ACC: begin
            if (mstep_ff <= 4'd2) begin
               xc_ff <= xc_ff + prod_sh;
            end else if (mstep_ff <= 4'd5) begin
               yc_ff <= yc_ff + prod_sh;
            end else if (mstep_ff <= 4'd8) begin
               wc_ff <= wc_ff + prod_sh;
            end else begin
               ht_ff <= prod_sh;
            end
            mstep_ff <= mstep_ff + 4'd1;
         end
         BK_CHECK: begin
            job_ff    <= 2'd0;
            status_ff <= behind ? STATUS_BEHIND : STATUS_VISIBLE;
         end
         BK_KLO: begin
            mag_ff <= mag_full[MAG_W-1:0];
            neg_ff <= neg_cur;
         end
         BK_KHI: begin
            nlo_ff <= prod_ff[52:0];
         end
         BK_DWAIT: begin
            if (div_done) begin
               res_ff[job_ff] <= res_in;
               job_ff         <= job_ff + 2'd1;
            end
         end
         BK_CENTRE: begin
            if (centred) begin
               status_ff <= STATUS_CENTRED;
            end
         end
         default: begin
            job_ff <= job_ff;
         end
      endcase
      if (rsp_load) begin
         rsp_tag_ff    <= tag_ff;
         rsp_status_ff <= status_ff;
         if (status_ff == STATUS_VISIBLE) begin
            rsp_x_ff   <= sat24(sum_x);
            rsp_top_ff <= sat24(sum_top);
            rsp_bot_ff <= sat24(sum_bot);
         end else begin
            rsp_x_ff   <= '0;
            rsp_top_ff <= '0;
            rsp_bot_ff <= '0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_tag    = rsp_tag_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_screen_x      = rsp_x_ff;
   assign rsp_screen_top    = rsp_top_ff;
   assign rsp_screen_bottom = rsp_bot_ff;

endmodule

`default_nettype wire

// File: hdl/perspective_point_projector.sv
// Top level of the perspective point projector: control registers and section wiring.
// Sequence: a load passes the front register and queue, then the idle engine writes it;
//   a point result follows ten multiply steps when behind, plus two divisions when centred
//   or four when visible (a division ends early if its quotient would overflow). A point
//   holds the engine until its result is registered; loads stream one a cycle while idle.
// Reset: synchronous, active high; clears the matrix to zero and the registers to defaults.
`default_nettype none

module perspective_point_projector
   import ppp_pkg::*;
#(
   parameter int TAG_SLOTS = TAG_SLOTS_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // request channel
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic                      req_type,
   input  wire logic [IDX_W-1:0]          req_coef_index,
   input  wire logic signed [COEF_W-1:0]  req_coef_value,
   input  wire logic signed [POS_W-1:0]   req_pos_x,
   input  wire logic signed [POS_W-1:0]   req_pos_y,
   input  wire logic signed [POS_W-1:0]   req_pos_z,
   input  wire logic [TAG_W-1:0]          req_point_tag,
   // response channel
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [TAG_W-1:0]               rsp_result_tag,
   output logic [1:0]                     rsp_status,
   output logic signed [OUT_W-1:0]        rsp_screen_x,
   output logic signed [OUT_W-1:0]        rsp_screen_top,
   output logic signed [OUT_W-1:0]        rsp_screen_bottom,
   // control register write port
   input  wire logic                      csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]      csr_index,
   input  wire logic [CSR_DATA_W-1:0]     csr_write_data
);

   // Control registers. The user must make writes only while the engine is idle; the block
   // does not enforce this, and the engine reads them directly without shadow copies.
   logic [13:0] screen_width_ff;
   logic [13:0] screen_height_ff;
   logic [9:0]  center_margin_ff;
   logic [15:0] near_limit_ff;
   logic [19:0] height_offset_ff;

   // front section to queue
   logic    front_valid, front_ready;
   cmd_type front_cmd;

   // queue to engine
   logic    queue_valid, queue_pop;
   cmd_type queue_cmd;

   // Drop writes to unknown indexes; keep only the low bits of each register.
   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= SCREEN_WIDTH_RESET;
         screen_height_ff <= SCREEN_HEIGHT_RESET;
         center_margin_ff <= CENTER_MARGIN_RESET;
         near_limit_ff    <= NEAR_LIMIT_RESET;
         height_offset_ff <= HEIGHT_OFFSET_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:  screen_width_ff  <= csr_write_data[13:0];
            CSR_SCREEN_HEIGHT: screen_height_ff <= csr_write_data[13:0];
            CSR_CENTER_MARGIN: center_margin_ff <= csr_write_data[9:0];
            CSR_NEAR_LIMIT:    near_limit_ff    <= csr_write_data[15:0];
            CSR_HEIGHT_OFFSET: height_offset_ff <= csr_write_data[19:0];
            default:           screen_width_ff  <= screen_width_ff;
         endcase
      end
   end

   // Front: register each request beat, decode its kind and fold the tag.
   ppp_front #(
      .TAG_SLOTS (TAG_SLOTS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_coef_index (req_coef_index),
      .req_coef_value (req_coef_value),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_pos_z      (req_pos_z),
      .req_point_tag  (req_point_tag),
      .cmd_valid      (front_valid),
      .cmd            (front_cmd),
      .cmd_ready      (front_ready)
   );

   // Queue: hold decoded beats so the front takes input while the engine works, until full.
   // Loads travel the same queue as points so a load never overtakes an earlier point.
   ppp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_cmd   (front_cmd),
      .push_ready (front_ready),
      .pop_valid  (queue_valid),
      .pop_cmd    (queue_cmd),
      .pop_ready  (queue_pop)
   );

   // Engine: apply loads, project points and hold the result until it is taken.
   ppp_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_valid         (queue_valid),
      .cmd               (queue_cmd),
      .cmd_pop           (queue_pop),
      .screen_width      (screen_width_ff),
      .screen_height     (screen_height_ff),
      .center_margin     (center_margin_ff),
      .near_limit        (near_limit_ff),
      .height_offset     (height_offset_ff),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_tag    (rsp_result_tag),
      .rsp_status        (rsp_status),
      .rsp_screen_x      (rsp_screen_x),
      .rsp_screen_top    (rsp_screen_top),
      .rsp_screen_bottom (rsp_screen_bottom)
   );

endmodule

`default_nettype wire
